>>> rtl/core/dgr_pkg.sv
// Shared types and constants of the grid DDA ray caster.
`default_nettype none
package dgr_pkg;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CAM,
        S_MULX,
        S_MULY,
        S_RAYY,
        S_DIVX,
        S_MULSX,
        S_DIVY,
        S_MULSY,
        S_SIDEY,
        S_STEP,
        S_TEST,
        S_DONE
    } dgr_state_t;

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    // configuration register indexes
    localparam logic [2:0] REG_PLAYER_X = 3'd0;
    localparam logic [2:0] REG_PLAYER_Y = 3'd1;
    localparam logic [2:0] REG_DIR_X    = 3'd2;
    localparam logic [2:0] REG_DIR_Y    = 3'd3;
    localparam logic [2:0] REG_PLANE_X  = 3'd4;
    localparam logic [2:0] REG_PLANE_Y  = 3'd5;

    // datapath widths
    localparam int NUM_W   = 25;   // dividend: 2^24 or column << 15
    localparam int DEN_W   = 27;   // divisor: |ray| or screen width
    localparam int CNT_W   = 5;    // divider step count, holds NUM_W
    localparam int CAM_W   = 26;   // signed cam, Q.14
    localparam int RAY_W   = 28;   // signed ray component, Q.14
    localparam int MUL_A_W = 27;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int DELTA_W = 25;   // up to 2^24, Q.10

    localparam logic [NUM_W-1:0] RECIP_NUM = NUM_W'(1 << 24);
    localparam int               CAM_BIAS  = 16384;
    localparam logic [17:0]      DIST_MAX  = 18'h3FFFF;

endpackage
`default_nettype wire

>>> rtl/core/dgr_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module dgr_div
    import dgr_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic      [NUM_W-1:0] quo
);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        diff      = trial - {1'b0, den_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = diff[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
`default_nettype wire

>>> rtl/core/dgr_map.sv
// One-bit wall map memory with clearing sweep after reset.
`default_nettype none
module dgr_map
    import dgr_pkg::*;
#(
    parameter int MAP_SIZE = 32
)
(
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     wr_en,
    input  wire logic [$clog2(MAP_SIZE*MAP_SIZE)-1:0]     wr_addr,
    input  wire logic                                     wr_data,
    input  wire logic [$clog2(MAP_SIZE*MAP_SIZE)-1:0]     rd_addr,
    output logic                                          rd_data,
    output logic                                          ready
);

    localparam int DEPTH = MAP_SIZE * MAP_SIZE;
    localparam int AW    = $clog2(DEPTH);

    logic          mem [DEPTH];
    logic [AW:0]   clr_reg;
    logic          rd_reg;

    assign ready = (clr_reg == (AW+1)'(DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (!ready)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ready)
        begin
            mem[clr_reg[AW-1:0]] <= 1'b0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    assign rd_data = rd_reg;

endmodule
`default_nettype wire

>>> rtl/core/grid_dda_raycaster_top.sv
// Grid DDA ray caster top level: sequencer, shared multiplier and DDA walk.
// Usage:
//  - Input channel (in_valid / in_stall): one beat is a command. command 0
//    writes one wall map cell (cell_row, cell_col, cell_is_wall) and gives
//    no result; command 1 casts the ray for screen_column.
//  - Output channel (out_valid / out_stall): one beat per cast, carrying the
//    column, perpendicular distance (Q8.10, saturating), hit side, hit cell
//    and a flag for rays that left the map. A result sits in an output
//    register, so a new command is taken while the result still waits.
//  - Config port (cfg_write / cfg_index / cfg_data): player position, view
//    direction and camera plane; write only while the block is idle.
//  - Per cast: three divisions on the one shared restoring divider
//    (cam, then 1/|ray_x| and 1/|ray_y|) plus six multiply and setup
//    states, then per grid step a step state and a map read state, then
//    a finishing state that loads the output register and returns to idle.
//  - Reset: state, output valid and config registers return to their
//    defaults and the map is swept clear, one cell per cycle, with in_stall high.
//  - A stalled result holds the finished cast; the next cast is computed
//    but waits in its last state until the output register is free.
`default_nettype none
module grid_dda_raycaster_top
    import dgr_pkg::*;
#(
    parameter int MAP_SIZE     = 32,
    parameter int SCREEN_WIDTH = 640
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // config
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        command,
    input  wire logic [9:0]  screen_column,
    input  wire logic [4:0]  cell_row,
    input  wire logic [4:0]  cell_col,
    input  wire logic        cell_is_wall,
    // output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [9:0]       cast_column,
    output logic [17:0]      wall_distance,
    output logic             hit_side,
    output logic [4:0]       hit_x,
    output logic [4:0]       hit_y,
    output logic             left_map
);

    localparam int AW       = $clog2(MAP_SIZE * MAP_SIZE);
    localparam int MAX_CELL = (MAP_SIZE > 32) ? MAP_SIZE : 32;
    localparam int CW       = $clog2(MAX_CELL) + 2;          // signed cell index
    localparam int SIDE_W   = DELTA_W + $clog2(MAX_CELL) + 3;

    // configuration registers
    logic [14:0]        player_x_reg, player_y_reg;
    logic signed [15:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;

    // sequencer and datapath registers
    dgr_state_t                state_reg, state_next;
    logic [9:0]                col_reg, col_next;
    logic signed [CAM_W-1:0]   cam_reg, cam_next;
    logic signed [PROD_W-1:0]  mul_reg, mul_next;
    logic signed [RAY_W-1:0]   rx_reg, rx_next, ry_reg, ry_next;
    logic [DELTA_W-1:0]        dx_reg, dx_next, dy_reg, dy_next;
    logic [SIDE_W-1:0]         sdx_reg, sdx_next, sdy_reg, sdy_next;
    logic signed [CW-1:0]      cx_reg, cx_next, cy_reg, cy_next;
    logic                      side_reg, side_next;
    logic                      left_reg, left_next;
    logic [17:0]               dist_reg, dist_next;

    // output register
    logic        ov_reg, ov_next;
    logic [9:0]  o_col_reg, o_col_next;
    logic [17:0] o_dist_reg, o_dist_next;
    logic        o_side_reg, o_side_next;
    logic [4:0]  o_hx_reg, o_hx_next, o_hy_reg, o_hy_next;
    logic        o_left_reg, o_left_next;

    // shared units
    logic                      div_start, div_done;
    logic [NUM_W-1:0]          div_num, div_quo;
    logic [DEN_W-1:0]          div_den;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic                      map_wr_en, map_rd, map_ready;
    logic [AW-1:0]             map_wr_addr, map_rd_addr;

    // helpers
    logic                      in_accept;
    logic                      zx, zy, step_x;
    logic [10:0]               d_x, d_y;
    logic [DEN_W-1:0]          abs_x, abs_y;
    logic signed [CW-1:0]      cxn, cyn;
    logic                      out_x, out_y, out_cur;
    logic [SIDE_W-1:0]         dist_raw;
    logic [17:0]               dist_sat;

    function automatic logic cell_out(input logic signed [CW-1:0] c);
        return c[CW-1] || (c >= $signed(CW'(MAP_SIZE)));
    endfunction

    function automatic logic [4:0] cell_clamp(input logic signed [CW-1:0] c);
        logic [CW-1:0] v;
        if (c[CW-1])
            v = '0;
        else if (c >= $signed(CW'(MAP_SIZE)))
            v = CW'(MAP_SIZE - 1);
        else
            v = c;
        return v[4:0];
    endfunction

    dgr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    dgr_map #(.MAP_SIZE(MAP_SIZE)) u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (cell_is_wall),
        .rd_addr (map_rd_addr),
        .rd_data (map_rd),
        .ready   (map_ready)
    );

    assign in_stall  = !((state_reg == S_IDLE) && map_ready);
    assign in_accept = in_valid && !in_stall;

    // map write, ignored outside the map
    assign map_wr_en = in_accept && (command == CMD_WRITE)
                       && (32'(cell_row) < 32'(MAP_SIZE))
                       && (32'(cell_col) < 32'(MAP_SIZE));
    assign map_wr_addr = AW'(AW'(cell_row) * AW'(MAP_SIZE) + AW'(cell_col));

    // ray and step terms
    assign zx    = (rx_reg == '0);
    assign zy    = (ry_reg == '0);
    assign abs_x = DEN_W'(rx_reg[RAY_W-1] ? -rx_reg : rx_reg);
    assign abs_y = DEN_W'(ry_reg[RAY_W-1] ? -ry_reg : ry_reg);
    assign d_x   = rx_reg[RAY_W-1] ? {1'b0, player_x_reg[9:0]}
                                   : 11'd1024 - {1'b0, player_x_reg[9:0]};
    assign d_y   = ry_reg[RAY_W-1] ? {1'b0, player_y_reg[9:0]}
                                   : 11'd1024 - {1'b0, player_y_reg[9:0]};
    // ties step along y
    assign step_x = !zx && (zy || (sdx_reg < sdy_reg));
    assign cxn    = step_x ? (rx_reg[RAY_W-1] ? cx_reg - 1'b1 : cx_reg + 1'b1) : cx_reg;
    assign cyn    = step_x ? cy_reg : (ry_reg[RAY_W-1] ? cy_reg - 1'b1 : cy_reg + 1'b1);
    assign out_x  = cell_out(cxn);
    assign out_y  = cell_out(cyn);
    // read address of the cell about to be entered; in-map only
    assign map_rd_addr = (out_x || out_y) ? '0
                       : AW'(AW'(cyn[CW-2:0]) * AW'(MAP_SIZE) + AW'(cxn[CW-2:0]));
    assign out_cur  = cell_out(cx_reg) || cell_out(cy_reg);
    assign dist_raw = side_reg ? sdy_reg - SIDE_W'(dy_reg) : sdx_reg - SIDE_W'(dx_reg);
    assign dist_sat = (dist_raw > SIDE_W'(DIST_MAX)) ? DIST_MAX : dist_raw[17:0];

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MULX:
            begin
                mul_a = MUL_A_W'(cam_reg);
                mul_b = MUL_B_W'(plane_x_reg);
            end
            S_MULY:
            begin
                mul_a = MUL_A_W'(cam_reg);
                mul_b = MUL_B_W'(plane_y_reg);
            end
            S_MULSX:
            begin
                mul_a = $signed({2'b0, dx_reg});
                mul_b = $signed({6'b0, d_x});
            end
            S_MULSY:
            begin
                mul_a = $signed({2'b0, dy_reg});
                mul_b = $signed({6'b0, d_y});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        col_next    = col_reg;
        cam_next    = cam_reg;
        mul_next    = mul_reg;
        rx_next     = rx_reg;
        ry_next     = ry_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        sdx_next    = sdx_reg;
        sdy_next    = sdy_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        side_next   = side_reg;
        left_next   = left_reg;
        dist_next   = dist_reg;
        div_start   = 1'b0;
        div_num     = RECIP_NUM;
        div_den     = abs_x;
        ov_next     = ov_reg && out_stall;
        o_col_next  = o_col_reg;
        o_dist_next = o_dist_reg;
        o_side_next = o_side_reg;
        o_hx_next   = o_hx_reg;
        o_hy_next   = o_hy_reg;
        o_left_next = o_left_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (command == CMD_CAST))
                begin
                    col_next   = screen_column;
                    div_start  = 1'b1;
                    div_num    = {screen_column, 15'b0};
                    div_den    = DEN_W'(SCREEN_WIDTH);
                    state_next = S_CAM;
                end
            end
            S_CAM:
            begin
                if (div_done)
                begin
                    cam_next   = $signed(CAM_W'(div_quo)) - $signed(CAM_W'(CAM_BIAS));
                    state_next = S_MULX;
                end
            end
            S_MULX:
            begin
                mul_next   = mul_a * mul_b;
                state_next = S_MULY;
            end
            S_MULY:
            begin
                rx_next    = RAY_W'(dir_x_reg) + RAY_W'(mul_reg >>> 14);
                mul_next   = mul_a * mul_b;
                state_next = S_RAYY;
            end
            S_RAYY:
            begin
                ry_next    = RAY_W'(dir_y_reg) + RAY_W'(mul_reg >>> 14);
                div_start  = 1'b1;
                div_den    = abs_x;
                cx_next    = CW'(player_x_reg[14:10]);
                cy_next    = CW'(player_y_reg[14:10]);
                side_next  = 1'b0;
                left_next  = 1'b0;
                state_next = S_DIVX;
            end
            S_DIVX:
            begin
                if (div_done)
                begin
                    dx_next    = zx ? '0 : div_quo;
                    state_next = S_MULSX;
                end
            end
            S_MULSX:
            begin
                mul_next   = mul_a * mul_b;
                div_start  = 1'b1;
                div_den    = abs_y;
                state_next = S_DIVY;
            end
            S_DIVY:
            begin
                sdx_next = zx ? '0 : SIDE_W'($unsigned(mul_reg >>> 10));
                if (div_done)
                begin
                    dy_next    = zy ? '0 : div_quo;
                    state_next = S_MULSY;
                end
            end
            S_MULSY:
            begin
                mul_next   = mul_a * mul_b;
                state_next = S_SIDEY;
            end
            S_SIDEY:
            begin
                sdy_next = zy ? '0 : SIDE_W'($unsigned(mul_reg >>> 10));
                if (zx && zy)
                begin
                    dist_next  = DIST_MAX;
                    left_next  = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (step_x)
                begin
                    sdx_next  = sdx_reg + SIDE_W'(dx_reg);
                    side_next = 1'b0;
                end
                else
                begin
                    sdy_next  = sdy_reg + SIDE_W'(dy_reg);
                    side_next = 1'b1;
                end
                cx_next    = cxn;
                cy_next    = cyn;
                state_next = S_TEST;
            end
            S_TEST:
            begin
                dist_next = dist_sat;
                if (out_cur)
                begin
                    left_next  = 1'b1;
                    state_next = S_DONE;
                end
                else if (map_rd)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end
            S_DONE:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next     = 1'b1;
                    o_col_next  = col_reg;
                    o_dist_next = dist_reg;
                    o_side_next = side_reg;
                    o_hx_next   = cell_clamp(cx_reg);
                    o_hy_next   = cell_clamp(cy_reg);
                    o_left_next = left_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ov_reg       <= 1'b0;
            player_x_reg <= 15'd16896;
            player_y_reg <= 15'd16896;
            dir_x_reg    <= 16'sd16384;
            dir_y_reg    <= 16'sd0;
            plane_x_reg  <= 16'sd0;
            plane_y_reg  <= 16'sd10813;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_PLAYER_X: player_x_reg <= cfg_data[14:0];
                    REG_PLAYER_Y: player_y_reg <= cfg_data[14:0];
                    REG_DIR_X:    dir_x_reg    <= cfg_data;
                    REG_DIR_Y:    dir_y_reg    <= cfg_data;
                    REG_PLANE_X:  plane_x_reg  <= cfg_data;
                    REG_PLANE_Y:  plane_y_reg  <= cfg_data;
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg    <= col_next;
        cam_reg    <= cam_next;
        mul_reg    <= mul_next;
        rx_reg     <= rx_next;
        ry_reg     <= ry_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        sdx_reg    <= sdx_next;
        sdy_reg    <= sdy_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        side_reg   <= side_next;
        left_reg   <= left_next;
        dist_reg   <= dist_next;
        o_col_reg  <= o_col_next;
        o_dist_reg <= o_dist_next;
        o_side_reg <= o_side_next;
        o_hx_reg   <= o_hx_next;
        o_hy_reg   <= o_hy_next;
        o_left_reg <= o_left_next;
    end

    assign out_valid     = ov_reg;
    assign cast_column   = o_col_reg;
    assign wall_distance = o_dist_reg;
    assign hit_side      = o_side_reg;
    assign hit_x         = o_hx_reg;
    assign hit_y         = o_hy_reg;
    assign left_map      = o_left_reg;

    // a new result only comes from the finishing state
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_DONE))
        else $error("result raised outside finishing state");

    // input taken only while idle and map clear done
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> (state_reg == S_IDLE) && map_ready)
        else $error("input accepted while busy");

    // a stalled result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall && state_reg == S_DONE) |=> (state_reg == S_DONE))
        else $error("finished cast left while output blocked");

    // walk starts only with a nonzero ray
    a_walk_ray: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STEP) |-> !(zx && zy))
        else $error("walk with zero ray");

endmodule
`default_nettype wire
